@@ rtl/core/tftp_request_parser_defines.svh @@
// Assertion macros shared by the checker of the TFTP request parser.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TFTP_REQUEST_PARSER_DEFINES_SVH
`define TFTP_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held
`define TRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trp check failed: same-cycle implication");

// Next-cycle implication, ignored while reset is held
`define TRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trp check failed: next-cycle implication");

`endif

@@ rtl/core/trp_pkg.sv @@
// Shared types, constants and mode tables of the TFTP request parser.
// No dependencies; imported by trp_in_reg, trp_parse_core and the top level.
package trp_pkg;

    // Default size limits, handed to the top-level parameters
    localparam int TRP_NAME_MAX = 256;
    localparam int TRP_MODE_MAX = 16;

    // Fixed protocol limits
    localparam logic [3:0]  TRP_MIN_PAYLOAD = 4'd10;
    localparam logic [15:0] TRP_OPCODE_LIMIT = 16'd6;

    // Mode result codes
    localparam logic [1:0] TRP_MODE_NETASCII = 2'd0;
    localparam logic [1:0] TRP_MODE_OCTET    = 2'd1;
    localparam logic [1:0] TRP_MODE_MAIL     = 2'd2;

    // Known transfer mode strings, padded with NUL
    localparam logic [7:0] TRP_MODE_TEXT [3][8] = '{
        '{8'h6e, 8'h65, 8'h74, 8'h61, 8'h73, 8'h63, 8'h69, 8'h69},
        '{8'h6f, 8'h63, 8'h74, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h6d, 8'h61, 8'h69, 8'h6c, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [4:0] TRP_MODE_LEN [3] = '{5'd8, 5'd5, 5'd4};

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } trp_word_t;

    // One result word
    typedef struct packed {
        logic [7:0]  name_char;
        logic        name_char_valid;
        logic        done_res;
        logic        accepted;
        logic [15:0] opcode;
        logic [1:0]  mode;
        logic [7:0]  name_length;
    } trp_result_t;

    // Candidates whose character at position pos equals c
    function automatic logic [2:0] trp_char_hits(input logic [4:0] pos, input logic [7:0] c);
        logic [2:0] hits;
        hits = '0;
        for (int k = 0; k < 3; k++) begin
            hits[k] = (pos < TRP_MODE_LEN[k]) && (TRP_MODE_TEXT[k][pos[2:0]] == c);
        end
        return hits;
    endfunction

    // Candidates whose length equals pos characters
    function automatic logic [2:0] trp_len_hits(input logic [4:0] pos);
        logic [2:0] hits;
        hits = '0;
        for (int k = 0; k < 3; k++) begin
            hits[k] = (pos == TRP_MODE_LEN[k]);
        end
        return hits;
    endfunction

endpackage

@@ rtl/core/trp_in_reg.sv @@
// Input register of the TFTP request parser: holds one accepted word.
// Depends on trp_pkg for the word type.
module trp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    output logic              word_valid,
    output trp_pkg::trp_word_t word,
    input  logic              take
);
    import trp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    trp_word_t word_reg;

    // Accept whenever the held word is empty or moves on this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tvalid ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg.data_byte <= s_tdata;
            word_reg.last_byte <= s_tlast;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ rtl/core/trp_parse_core.sv @@
// Parse state and result register of the TFTP request parser.
// Depends on trp_pkg for types, limits and the mode tables.
module trp_parse_core #(
    parameter int NAME_MAX = trp_pkg::TRP_NAME_MAX,
    parameter int MODE_MAX = trp_pkg::TRP_MODE_MAX
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    input  trp_pkg::trp_word_t  word,
    output logic                take,
    output logic                res_valid,
    output trp_pkg::trp_result_t res,
    input  logic                res_ready
);
    import trp_pkg::*;

    localparam int NCW = $clog2(NAME_MAX + 1);
    localparam int MPW = $clog2(MODE_MAX + 1);

    // Phase codes
    localparam logic [2:0] PH_OPHI = 3'd0;
    localparam logic [2:0] PH_OPLO = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_MODE = 3'd3;
    localparam logic [2:0] PH_TAIL = 3'd4;
    localparam logic [2:0] PH_DROP = 3'd5;

    logic [2:0]     phase_reg, phase_next;
    logic [15:0]    opcode_reg, opcode_next;
    logic [3:0]     byte_count_reg, byte_count_next;
    logic [NCW-1:0] name_count_reg, name_count_next;
    logic [MPW-1:0] mode_pos_reg, mode_pos_next;
    logic [2:0]     mode_match_reg, mode_match_next;
    logic           reject_reg, reject_next;
    logic           res_valid_reg;
    trp_result_t    res_reg, res_next;
    logic           ok;

    // Advance when the result register is free or drains this cycle
    assign take = word_valid && (!res_valid_reg || res_ready);

    // Per-byte parse step
    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        name_count_next = name_count_reg;
        mode_pos_next   = mode_pos_reg;
        mode_match_next = mode_match_reg;
        reject_next     = reject_reg;
        res_next        = '0;
        ok              = 1'b0;

        byte_count_next = (byte_count_reg < TRP_MIN_PAYLOAD) ? byte_count_reg + 4'd1
                                                             : byte_count_reg;

        case (phase_reg)
            PH_OPHI:
            begin
                opcode_next = {word.data_byte, 8'h00};
                phase_next  = PH_OPLO;
            end
            PH_OPLO:
            begin
                opcode_next = {opcode_reg[15:8], word.data_byte};
                if (opcode_next >= TRP_OPCODE_LIMIT)
                begin
                    reject_next = 1'b1;
                    phase_next  = PH_DROP;
                end
                else
                begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (word.data_byte == 8'h00)
                begin
                    phase_next      = PH_MODE;
                    mode_pos_next   = '0;
                    mode_match_next = 3'b111;
                end
                else
                begin
                    res_next.name_char       = word.data_byte;
                    res_next.name_char_valid = 1'b1;
                    name_count_next          = name_count_reg + NCW'(1);
                    if (name_count_next >= NCW'(NAME_MAX))
                    begin
                        reject_next = 1'b1;
                        phase_next  = PH_DROP;
                    end
                end
            end
            PH_MODE:
            begin
                if (word.data_byte == 8'h00)
                begin
                    mode_match_next = mode_match_reg & trp_len_hits(5'(mode_pos_reg));
                    if (mode_match_next == 3'b000)
                    begin
                        reject_next = 1'b1;
                        phase_next  = PH_DROP;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                else
                begin
                    mode_match_next = mode_match_reg &
                                      trp_char_hits(5'(mode_pos_reg), word.data_byte);
                    mode_pos_next   = mode_pos_reg + MPW'(1);
                    if (mode_pos_next >= MPW'(MODE_MAX))
                    begin
                        reject_next = 1'b1;
                        phase_next  = PH_DROP;
                    end
                end
            end
            PH_TAIL:
            begin
                phase_next = PH_TAIL;
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase

        // Verdict on the final byte, then back to the start state
        if (word.last_byte)
        begin
            ok = !reject_next && (phase_next == PH_TAIL) &&
                 (byte_count_next >= TRP_MIN_PAYLOAD);
            res_next.done_res = 1'b1;
            res_next.accepted = ok;
            res_next.opcode   = opcode_next;
            if (ok)
            begin
                res_next.mode = mode_match_next[0] ? TRP_MODE_NETASCII :
                                (mode_match_next[1] ? TRP_MODE_OCTET : TRP_MODE_MAIL);
            end
            res_next.name_length = (name_count_next > NCW'(255)) ? 8'hff
                                                                 : 8'(name_count_next);
            phase_next      = PH_OPHI;
            opcode_next     = '0;
            byte_count_next = '0;
            name_count_next = '0;
            mode_pos_next   = '0;
            mode_match_next = 3'b111;
            reject_next     = 1'b0;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPHI;
            opcode_reg     <= '0;
            byte_count_reg <= '0;
            name_count_reg <= '0;
            mode_pos_reg   <= '0;
            mode_match_reg <= 3'b111;
            reject_reg     <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            byte_count_reg <= byte_count_next;
            name_count_reg <= name_count_next;
            mode_pos_reg   <= mode_pos_next;
            mode_match_reg <= mode_match_next;
            reject_reg     <= reject_next;
        end
    end

    // Result valid: set on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/tftp_request_parser.sv @@
// TFTP read/write request parser, top level.
//
// Usage:
//   Slave stream: one UDP payload byte per word in s_tdata, s_tlast on the
//   final byte of the payload. Master stream: exactly one result word per
//   input word. m_tuser flags an echoed filename character in m_tdata[7:0];
//   m_tlast marks the verdict word (accepted, opcode, mode, name length),
//   which comes with the final payload byte. Verdict fields read zero on
//   other words, as does the character field when m_tuser is low.
//   An accepted byte passes the input register, then the parse step into the
//   result register, from which its result word is sent.
//   Throughput: one byte per cycle while m_tready is high, set by the parse
//   step that updates the phase, counters and mode candidates of the request.
//   After the verdict word the parser is back at the start of a request.
//   Reset clears the parse state and both valid flags; the block is ready
//   at once. When the receiver stalls, the result word holds, the input
//   register fills, and s_tready falls one word later.
// Depends on trp_pkg, trp_in_reg and trp_parse_core.
module tftp_request_parser #(
    parameter int NAME_MAX = trp_pkg::TRP_NAME_MAX,
    parameter int MODE_MAX = trp_pkg::TRP_MODE_MAX
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // name_char[7:0], accepted[8], opcode[24:9],
                                   // mode[26:25], name_length[34:27], zero[39:35]
    output logic        m_tuser,   // name_char_valid
    output logic        m_tlast    // done_res
);
    import trp_pkg::*;

    logic        word_valid;
    trp_word_t   word;
    logic        take;
    trp_result_t res;

    trp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .word_valid (word_valid),
        .word       (word),
        .take       (take)
    );

    trp_parse_core #(
        .NAME_MAX (NAME_MAX),
        .MODE_MAX (MODE_MAX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .take       (take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    // Pack the result word
    assign m_tdata = {5'b00000, res.name_length, res.mode, res.opcode,
                      res.accepted, res.name_char};
    assign m_tuser = res.name_char_valid;
    assign m_tlast = res.done_res;

endmodule

@@ rtl/core/trp_checker.sv @@
// Port-level checks of the TFTP request parser, bound to the top level.
// Depends on tftp_request_parser_defines.svh for the assertion macros.
`include "tftp_request_parser_defines.svh"

module trp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic verdict_legal;

    // Verdict word with a legal opcode and a known mode
    assign verdict_legal = m_tlast && (m_tdata[24:9] < 16'd6) && (m_tdata[26:25] != 2'b11);

    // Stalled result word holds
    `TRP_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

    // Verdict fields and padding stay zero away from the verdict word
    `TRP_ASSERT_IMP(a_quiet, m_tvalid && !m_tlast, m_tdata[39:8] == 32'd0)

    // No character without the echo flag
    `TRP_ASSERT_IMP(a_char, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)

    // An accepted request has a legal opcode and a known mode
    `TRP_ASSERT_IMP(a_accept, m_tvalid && m_tdata[8], verdict_legal)

endmodule

bind tftp_request_parser trp_checker u_trp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
